FILE: src/spm_pkg.sv
// Shared types and constants for the stream phrase matcher.
`default_nettype none
package spm_pkg;

  localparam int DEF_MAX_PATTERN = 32;
  localparam int PAT_WORDS       = 4;
  localparam int PAT_WORD_W      = 64;
  localparam int LEN_W           = 6;
  localparam int OFS_W           = 32;
  localparam int ADDR_W          = 6;
  localparam int PIDX_W          = 5;

  localparam logic [2:0] REG_LEN    = 3'd0;
  localparam logic [2:0] REG_WORD_0 = 3'd1;
  localparam logic [2:0] REG_WORD_1 = 3'd2;
  localparam logic [2:0] REG_WORD_2 = 3'd3;
  localparam logic [2:0] REG_WORD_3 = 3'd4;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] start;
    logic             done;
  } result_t;

endpackage
`default_nettype wire

FILE: src/spm_cell.sv
// One window cell: holds one earlier byte, passes it on, and compares it.
`default_nettype none
module spm_cell (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       shift_en,
  input  wire logic       clear,
  input  wire logic [7:0] din,
  input  wire logic [7:0] ref_byte,
  input  wire logic       active,
  output logic      [7:0] dout,
  output logic            ok
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (shift_en) begin
      held <= clear ? 8'd0 : din;
    end
  end

  assign dout = held;
  assign ok   = !active || (held == ref_byte);

endmodule
`default_nettype wire

FILE: src/spm_out_fifo.sv
// Two-entry result queue between the compare row and the output stream.
`default_nettype none
module spm_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire spm_pkg::result_t push_data,
  output logic                  full,
  output logic                  valid,
  input  wire logic             pop,
  output spm_pkg::result_t      head
);
  import spm_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/stream_phrase_matcher_unit.sv
// Top level: exact phrase search over a byte stream with a row of window cells.
// Takes one byte per cycle while the queue has room. A row of MAX_PATTERN-1 cells
// holds the earlier bytes of the current file, shifting one place per accepted
// byte, and each cell compares its byte with the phrase byte aligned to it;
// the AND of the cell results, the compare of the incoming byte and the
// byte count give the result in the same cycle. The result is registered into
// a two-entry output queue and is offered on the master side from the next
// cycle on, so the input keeps flowing for one extra item while the output is
// stalled. The window and the byte offset clear after a byte with tlast.
// Configuration must be written over the APB port while no request is in flight; the block does not check this.
`default_nettype none
module stream_phrase_matcher_unit #(
  parameter int MAX_PATTERN = spm_pkg::DEF_MAX_PATTERN
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // s_tdata: data_byte [7:0]; s_tlast: end_of_file
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,
  input  wire logic                          s_tlast,
  // m_tdata: match_start [31:0]; m_tuser: match_found; m_tlast: file_done
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [spm_pkg::OFS_W-1:0]          m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spm_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [spm_pkg::PAT_WORD_W-1:0] pwdata,
  output logic      [spm_pkg::PAT_WORD_W-1:0] prdata,
  output logic                               pready
);
  import spm_pkg::*;

  localparam int CELLS = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [LEN_W-1:0]                      pat_len;
  logic [PAT_WORDS-1:0][PAT_WORD_W-1:0]  pat_word;
  logic [PAT_WORDS*PAT_WORD_W-1:0]       phrase_bits;
  logic [LEN_W-1:0]                      len_eff;
  logic [OFS_W-1:0]                      bytes_seen;
  logic [OFS_W-1:0]                      len_less1;
  logic                                  accept;
  logic                                  cfg_wr;
  logic [2:0]                            reg_idx;
  logic [7:0]                            win     [CELLS];
  logic [7:0]                            ref_b   [CELLS];
  logic [CELLS-1:0]                      cell_ok;
  logic [CELLS-1:0]                      cell_act;
  logic [PIDX_W-1:0]                     last_idx;
  logic                                  last_eq;
  logic                                  seen_ok;
  logic                                  fifo_full;
  result_t                               res;
  result_t                               head;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign reg_idx     = paddr[5:3];
  assign phrase_bits = pat_word;
  assign len_eff     = (pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len  <= LEN_W'(1);
      pat_word <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LEN:    pat_len     <= pwdata[LEN_W-1:0];
        REG_WORD_0: pat_word[0] <= pwdata;
        REG_WORD_1: pat_word[1] <= pwdata;
        REG_WORD_2: pat_word[2] <= pwdata;
        REG_WORD_3: pat_word[3] <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEN:    prdata = {{(PAT_WORD_W-LEN_W){1'b0}}, pat_len};
      REG_WORD_0: prdata = pat_word[0];
      REG_WORD_1: prdata = pat_word[1];
      REG_WORD_2: prdata = pat_word[2];
      REG_WORD_3: prdata = pat_word[3];
      default:    prdata = '0;
    endcase
  end

  assign s_tready = !fifo_full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen <= '0;
      end else if (bytes_seen != '1) begin
        bytes_seen <= bytes_seen + OFS_W'(1);
      end
    end
  end

  // cell k holds the byte k+1 places back and meets phrase byte len-2-k
  genvar k;
  generate
    for (k = 0; k < CELLS; k++) begin : g_cell
      logic [PIDX_W-1:0] pidx;
      assign pidx        = PIDX_W'(len_eff - LEN_W'(k + 2));
      assign cell_act[k] = (LEN_W'(k + 2) <= len_eff);
      assign ref_b[k]    = phrase_bits[8*pidx +: 8];
      spm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (accept),
        .clear    (s_tlast),
        .din      ((k == 0) ? s_tdata : win[(k == 0) ? 0 : k-1]),
        .ref_byte (ref_b[k]),
        .active   (cell_act[k]),
        .dout     (win[k]),
        .ok       (cell_ok[k])
      );
    end
  endgenerate

  assign last_idx  = PIDX_W'(len_eff - LEN_W'(1));
  assign last_eq   = (phrase_bits[8*last_idx +: 8] == s_tdata);
  assign len_less1 = OFS_W'(len_eff) - OFS_W'(1);
  assign seen_ok   = (bytes_seen >= len_less1);

  always_comb begin
    res.found = (len_eff != '0) && seen_ok && last_eq && (&cell_ok);
    res.start = res.found ? (bytes_seen - len_less1) : '0;
    res.done  = s_tlast;
  end

  spm_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (fifo_full),
    .valid     (m_tvalid),
    .pop       (m_tready),
    .head      (head)
  );

  assign m_tdata = head.start;
  assign m_tuser = head.found;
  assign m_tlast = head.done;

endmodule
`default_nettype wire

FILE: src/spm_checker.sv
// Port-level checks for the stream phrase matcher, bound to the top level.
`default_nettype none
module spm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request produced no result");

  a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

  a_no_match_zero_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("nonzero start without a match");

endmodule

bind stream_phrase_matcher_unit spm_checker u_spm_checker (.*);
`default_nettype wire

FILE: tb/sv/spm_stream_checker.sv
// Checker for the phrase matcher: tracks config writes, predicts each result, compares.
`timescale 1ns / 1ps
module spm_stream_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [7:0]                     s_tdata,
  input  wire logic                           s_tlast,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [spm_pkg::OFS_W-1:0]      m_tdata,
  input  wire logic                           m_tuser,
  input  wire logic                           m_tlast,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [spm_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [spm_pkg::PAT_WORD_W-1:0] pwdata,
  input  wire logic                           pready,
  output int                                  errors,
  output int                                  pending,
  output int                                  hits
);
  import spm_pkg::*;

  localparam int MAXP   = DEF_MAX_PATTERN;
  localparam int QDEPTH = 8;

  logic [LEN_W-1:0]      phrase_len;
  logic [PAT_WORD_W-1:0] phrase_word [PAT_WORDS];
  logic [7:0]            history [MAXP-1];
  logic [OFS_W-1:0]      file_offset;
  result_t               exp_buf [QDEPTH];
  int                    rd_pos = 0;
  int                    wr_pos = 0;
  int                    err_count = 0;
  int                    hit_count = 0;
  int                    queued = 0;

  assign errors  = err_count;
  assign pending = queued;
  assign hits    = hit_count;

  always @(posedge clk) begin : track
    result_t want;
    result_t got;
    int      eff;
    int      k;
    logic    hit;
    logic [7:0] pb;
    if (rst) begin
      phrase_len = 1;
      for (k = 0; k < PAT_WORDS; k++) phrase_word[k] = '0;
      for (k = 0; k < MAXP-1; k++) history[k] = '0;
      file_offset = '0;
      rd_pos = 0;
      wr_pos = 0;
      queued = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_LEN:    phrase_len     = pwdata[LEN_W-1:0];
          REG_WORD_0: phrase_word[0] = pwdata;
          REG_WORD_1: phrase_word[1] = pwdata;
          REG_WORD_2: phrase_word[2] = pwdata;
          REG_WORD_3: phrase_word[3] = pwdata;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got.found = m_tuser;
        got.start = m_tdata;
        got.done  = m_tlast;
        if (got.found) hit_count++;
        if (queued == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, actual found=%0b start=%0h done=%0b",
                   $time, got.found, got.start, got.done);
        end else begin
          want = exp_buf[rd_pos];
          rd_pos = (rd_pos + 1) % QDEPTH;
          queued--;
          if (got.found !== want.found) begin
            err_count++;
            $display("%0t: match_found mismatch: expected %0b, actual %0b",
                     $time, want.found, got.found);
          end
          if (got.start !== want.start) begin
            err_count++;
            $display("%0t: match_start mismatch: expected %0h, actual %0h",
                     $time, want.start, got.start);
          end
          if (got.done !== want.done) begin
            err_count++;
            $display("%0t: file_done mismatch: expected %0b, actual %0b",
                     $time, want.done, got.done);
          end
        end
      end

      if (s_tvalid && s_tready) begin
        eff = (phrase_len > MAXP) ? MAXP : phrase_len;
        hit = 1'b0;
        want.start = '0;
        if (eff >= 1 && file_offset >= eff - 1) begin
          hit = 1'b1;
          for (k = 0; k < eff; k++) begin
            pb = phrase_word[k/8][(k%8)*8 +: 8];
            if (k == eff - 1) hit &= (pb == s_tdata);
            else              hit &= (pb == history[eff-2-k]);
          end
          if (hit) want.start = file_offset - OFS_W'(eff - 1);
        end
        want.found = hit;
        want.done  = s_tlast;
        if (queued == QDEPTH) begin
          err_count++;
          $display("%0t: results overdue: expected at most %0d pending, actual %0d",
                   $time, QDEPTH - 1, queued);
        end else begin
          exp_buf[wr_pos] = want;
          wr_pos = (wr_pos + 1) % QDEPTH;
          queued++;
        end
        for (k = MAXP-2; k > 0; k--) history[k] = history[k-1];
        history[0] = s_tdata;
        if (file_offset != '1) file_offset++;
        if (s_tlast) begin
          for (k = 0; k < MAXP-1; k++) history[k] = '0;
          file_offset = '0;
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_stream_phrase_matcher_unit.sv
// Testbench top for the phrase matcher: clock, reset, byte stream and config stimulus.
`timescale 1ns / 1ps
module tb_stream_phrase_matcher_unit;
  import spm_pkg::*;

  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int         RUN_PHASES   = 12;
  localparam int         PHASE_BYTES  = 105;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OFS_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [PAT_WORD_W-1:0] pwdata;
  logic [PAT_WORD_W-1:0] prdata;
  logic                  pready;

  int   errors;
  int   pending;
  int   hits;
  logic steady;
  int   bytes_sent;
  int   files_sent;
  int   settings;
  logic [7:0] phrase [DEF_MAX_PATTERN];
  logic [7:0] alpha [4];
  logic [2:0] word_reg [PAT_WORDS] = '{REG_WORD_0, REG_WORD_1, REG_WORD_2, REG_WORD_3};
  int   lens [RUN_PHASES] = '{1, 2, 3, 5, 8, 9, 16, 24, 31, 32, 40, 63};

  stream_phrase_matcher_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  spm_stream_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .errors(errors), .pending(pending), .hits(hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  always @(negedge clk) m_tready <= steady || ($urandom_range(0, 99) >= 35);

  task automatic program_reg(input logic [2:0] idx, input logic [PAT_WORD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
    if (last) files_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_phrase(input int len);
    logic [PAT_WORD_W-1:0] word;
    int w;
    int b;
    settings++;
    program_reg(REG_LEN, PAT_WORD_W'(len));
    for (w = 0; w < PAT_WORDS; w++) begin
      for (b = 0; b < 8; b++) word[b*8 +: 8] = phrase[w*8 + b];
      program_reg(word_reg[w], word);
    end
  endtask

  // most bytes walk through the phrase, with restarts, filler and noise mixed in
  task automatic send_file(input int eff);
    int flen;
    int j;
    int p;
    int r;
    logic [7:0] b;
    p = 0;
    if ($urandom_range(0, 3) == 0) flen = $urandom_range(1, eff + 2);
    else                           flen = $urandom_range(1, 2 * eff + 24);
    for (j = 0; j < flen; j++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        b = phrase[p];
        p = (p + 1) % eff;
      end else if (r < 70) begin
        b = phrase[0];
        p = (eff > 1) ? 1 : 0;
      end else if (r < 95) begin
        b = alpha[$urandom_range(0, 3)];
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b, j == flen - 1);
    end
  endtask

  initial begin
    int ph;
    int k;
    int eff;
    int start_bytes;
    rst = 1'b1;
    steady = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bytes_sent = 0;
    files_sent = 0;
    settings = 1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: one-byte phrase of zero
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    // "aba": short file, no match across files, overlapping hits
    for (k = 0; k < DEF_MAX_PATTERN; k++) phrase[k] = 8'h00;
    phrase[0] = 8'h61;
    phrase[1] = 8'h62;
    phrase[2] = 8'h61;
    load_phrase(3);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b1);
    settle();

    // unmapped addresses are ignored; zero length never matches
    program_reg(REG_SPARE_LO, '1);
    program_reg(REG_SPARE_HI, '1);
    program_reg(REG_LEN, '0);
    settings++;
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b1);
    settle();

    for (ph = 0; ph < RUN_PHASES; ph++) begin
      for (k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(0, 255));
      if (ph % 3 == 0) alpha[1] = alpha[0];
      for (k = 0; k < DEF_MAX_PATTERN; k++) phrase[k] = alpha[$urandom_range(0, 1)];
      load_phrase(lens[ph]);
      eff = (lens[ph] > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : lens[ph];
      steady = (ph == 6);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES) send_file(eff);
      settle();
      steady = 1'b0;
    end

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Run covered %0d bytes in %0d files over %0d phrase settings.",
             bytes_sent, files_sent, settings);
    $display("Results reporting a match: %0d.", hits);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/spm_pkg.sv
src/spm_cell.sv
src/spm_out_fifo.sv
src/stream_phrase_matcher_unit.sv
src/spm_checker.sv
tb/sv/spm_stream_checker.sv
tb/sv/tb_stream_phrase_matcher_unit.sv
